### rtl/lme_pkg.sv
// ----------------------------------------------------------------------------
// lme_pkg: shared types and constants of the LSB message extractor
// Holds the word formats of the input and result channels, the phase and
// status codes, the register indexes and the marker character lookup.
// ----------------------------------------------------------------------------
package lme_pkg;

  // Marker limits: the design limit and the number of characters that fit
  // in the 32-bit marker register.
  localparam int MARKER_CHARS = 4;
  localparam int WORD_CHARS   = 4;
  localparam logic [2:0] MARKER_MAX =
    3'((MARKER_CHARS < WORD_CHARS) ? MARKER_CHARS : WORD_CHARS);

  // Register reset values.
  localparam logic [31:0] MARKER_WORD_RESET   = 32'h4D53_473A;
  localparam logic [2:0]  MARKER_LENGTH_RESET = 3'd4;

  // Register indexes on the write port.
  localparam logic REG_MARKER_WORD   = 1'b0;
  localparam logic REG_MARKER_LENGTH = 1'b1;

  // Extraction phase of the current image.
  typedef enum logic [1:0] {
    PH_MARKER  = 2'd0,
    PH_MESSAGE = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  // Status codes carried by each result word.
  typedef enum logic [1:0] {
    STAT_BUSY      = 2'd0,
    STAT_COMPLETE  = 2'd1,
    STAT_NO_MARKER = 2'd2
  } status_t;

  // One input word.
  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       first_byte;
    logic       last_byte;
  } item_t;

  // One result word.
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    status_t    status;
    logic       last;
  } result_t;

  // Picks marker character sel, the first character sitting in the high byte.
  function automatic logic [7:0] marker_char(logic [31:0] word, logic [1:0] sel);
    logic [7:0] ch;
    unique case (sel)
      2'd0: ch = word[31:24];
      2'd1: ch = word[23:16];
      2'd2: ch = word[15:8];
      default: ch = word[7:0];
    endcase
    return ch;
  endfunction

endpackage

### rtl/lme_in_reg.sv
// ----------------------------------------------------------------------------
// lme_in_reg: input register of the LSB message extractor
// Captures one input word per cycle while the extraction stage keeps up,
// and holds it until the extraction stage consumes it.
// ----------------------------------------------------------------------------
module lme_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lme_pkg::item_t in_item,
  output logic           s_valid,
  input  logic           s_ready,
  output lme_pkg::item_t s_item
);
  import lme_pkg::*;

  // The register takes a new word whenever it is empty or being drained.
  assign in_ready = !s_valid || s_ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_item <= in_item;
    end
  end

endmodule

### rtl/lme_extract.sv
// ----------------------------------------------------------------------------
// lme_extract: bit gathering and marker/message evaluation
// Holds the per-image state, shifts in one LSB per word, evaluates each
// completed character against the marker or as message text, and forms
// at most one result word per input word.
// ----------------------------------------------------------------------------
module lme_extract (
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      marker_word,
  input  logic [2:0]       marker_length,
  input  logic             s_valid,
  output logic             s_ready,
  input  lme_pkg::item_t   s_item,
  output logic             res_valid,
  input  logic             res_ready,
  output lme_pkg::result_t res
);
  import lme_pkg::*;

  // State registers.
  phase_t     phase;
  logic [7:0] bit_accumulator;
  logic [2:0] bit_count;
  logic [2:0] marker_index;

  phase_t     phase_next;
  logic [7:0] bit_accumulator_next;
  logic [2:0] bit_count_next;
  logic [2:0] marker_index_next;

  // Datapath intermediates.
  phase_t     cur_phase;
  phase_t     eval_phase;
  logic [7:0] cur_acc;
  logic [2:0] cur_cnt;
  logic [2:0] cur_idx;
  logic [7:0] acc_shift;
  logic [2:0] cnt_inc;
  logic [2:0] idx_inc;
  logic [2:0] eff_len;
  logic       have_char;
  logic       char_ok;
  logic       has_result;
  logic       advance;

  // Effective marker length is capped by what the design supports.
  assign eff_len = (marker_length > MARKER_MAX) ? MARKER_MAX : marker_length;

  // A first byte restarts the image before the byte itself is used.
  always_comb begin
    if (s_item.first_byte) begin
      cur_phase = PH_MARKER;
      cur_acc   = 8'd0;
      cur_cnt   = 3'd0;
      cur_idx   = 3'd0;
    end else begin
      cur_phase = phase;
      cur_acc   = bit_accumulator;
      cur_cnt   = bit_count;
      cur_idx   = marker_index;
    end
  end

  // Shift in the LSB; a character completes on the eighth bit or at image end.
  assign acc_shift = {cur_acc[6:0], s_item.pixel_byte[0]};
  assign cnt_inc   = cur_cnt + 3'd1;
  assign have_char = (cnt_inc == 3'd0) || s_item.last_byte;
  assign idx_inc   = cur_idx + 3'd1;

  // A marker that is already complete moves the image to the message phase.
  assign eval_phase = (cur_phase == PH_MARKER && cur_idx >= eff_len) ? PH_MESSAGE
                                                                     : cur_phase;
  assign char_ok = (acc_shift != 8'd0) &&
                   (acc_shift == marker_char(marker_word, cur_idx[1:0]));

  // Next state.
  always_comb begin
    phase_next           = cur_phase;
    bit_accumulator_next = acc_shift;
    bit_count_next       = cnt_inc;
    marker_index_next    = cur_idx;
    if (cur_phase == PH_DONE) begin
      bit_accumulator_next = cur_acc;
      bit_count_next       = cur_cnt;
    end else if (have_char) begin
      bit_accumulator_next = 8'd0;
      bit_count_next       = 3'd0;
      phase_next           = eval_phase;
      if (eval_phase == PH_MARKER) begin
        if (!char_ok) begin
          phase_next = PH_DONE;
        end else begin
          marker_index_next = idx_inc;
          if (idx_inc >= eff_len) begin
            phase_next = PH_MESSAGE;
          end
        end
      end else if (acc_shift == 8'd0) begin
        phase_next = PH_DONE;
      end
      if (s_item.last_byte) begin
        phase_next = PH_DONE;
      end
    end
  end

  // Result word.
  always_comb begin
    res.out_char   = 8'd0;
    res.char_valid = 1'b0;
    res.status     = STAT_BUSY;
    res.last       = 1'b0;
    if (cur_phase != PH_DONE && have_char) begin
      if (eval_phase == PH_MARKER) begin
        if (!char_ok) begin
          res.status = STAT_NO_MARKER;
          res.last   = 1'b1;
        end else if (s_item.last_byte) begin
          res.status = (idx_inc < eff_len) ? STAT_NO_MARKER : STAT_COMPLETE;
          res.last   = 1'b1;
        end
      end else if (acc_shift == 8'd0) begin
        res.status = STAT_COMPLETE;
        res.last   = 1'b1;
      end else begin
        res.out_char   = acc_shift;
        res.char_valid = 1'b1;
        if (s_item.last_byte) begin
          res.status = STAT_COMPLETE;
          res.last   = 1'b1;
        end
      end
    end
  end

  // A word without a result passes even while the output side stalls.
  assign has_result = res.char_valid || res.last;
  assign advance    = s_valid && (!has_result || res_ready);
  assign s_ready    = !s_valid || advance;
  assign res_valid  = s_valid && has_result;

  // State update once per consumed word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_MARKER;
      bit_accumulator <= 8'd0;
      bit_count       <= 3'd0;
      marker_index    <= 3'd0;
    end else if (advance) begin
      phase           <= phase_next;
      bit_accumulator <= bit_accumulator_next;
      bit_count       <= bit_count_next;
      marker_index    <= marker_index_next;
    end
  end

  // A message character never comes with a missing-marker status.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.char_valid |-> res.status != STAT_NO_MARKER)
    else $error("message character reported with no-marker status");

  // The final result of an image leaves the block done with no bits pending.
  assert property (@(posedge clk) disable iff (rst)
    advance && res.last |=> phase == PH_DONE && bit_count == 3'd0)
    else $error("final result did not end the image");

  // A finished image stays finished until a first byte arrives.
  assert property (@(posedge clk) disable iff (rst)
    advance && phase == PH_DONE && !s_item.first_byte |=> phase == PH_DONE)
    else $error("finished image resumed without a first byte");

  // Nothing is reported for bytes that follow the end of an image.
  assert property (@(posedge clk) disable iff (rst)
    s_valid && phase == PH_DONE && !s_item.first_byte |-> !res_valid)
    else $error("result produced after image end");

endmodule

### rtl/lme_out_reg.sv
// ----------------------------------------------------------------------------
// lme_out_reg: result register of the LSB message extractor
// Holds one result word until the receiver takes it and accepts the next
// one in the same cycle as the current one leaves.
// ----------------------------------------------------------------------------
module lme_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lme_pkg::result_t in_res,
  output logic             out_valid,
  input  logic             out_ready,
  output lme_pkg::result_t out_res
);
  import lme_pkg::*;

  // Free when empty or when the held word is being taken.
  assign in_ready = !out_valid || out_ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_res <= in_res;
    end
  end

endmodule

### rtl/lsb_message_extractor.sv
// ----------------------------------------------------------------------------
// lsb_message_extractor: recovers a text message hidden in image byte LSBs
//
// Input channel (in_valid/in_ready): one image byte per word, with
// first_byte marking the start of an image and last_byte its end. Eight
// LSBs, first bit most significant, form one character. The first
// characters must match the marker register; later characters are sent on
// the output channel (out_valid/out_ready) until a null or the image end.
// The final result word of an image carries last = 1 and its status.
// Write port (wr_en/wr_index/wr_data) sets the marker registers; write
// them only while no image is in flight. A word taken into the input
// register is evaluated combinationally from it, and its result is loaded
// into the result register, which offers it on the output channel.
// Throughput is one word per cycle, set by the single evaluation stage,
// while the receiver keeps taking results.
// Input words that produce no result pass even while the receiver stalls;
// a waiting result holds the input side once the input register is full.
// Reset clears both stages, restores the marker to "MSG:" of length four
// and treats the stream as an image already started.
// ----------------------------------------------------------------------------
module lsb_message_extractor (
  input  logic        clk,
  input  logic        rst,
  // Register write port
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [31:0] wr_data,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pixel_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  // Output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        char_valid,
  output logic [1:0]  status,
  output logic        last
);
  import lme_pkg::*;

  logic [31:0] marker_word;
  logic [2:0]  marker_length;

  item_t   in_item;
  item_t   s_item;
  logic    s_valid;
  logic    s_ready;
  result_t res;
  logic    res_valid;
  logic    res_ready;
  result_t out_res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      marker_word   <= MARKER_WORD_RESET;
      marker_length <= MARKER_LENGTH_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MARKER_WORD:   marker_word   <= wr_data;
        REG_MARKER_LENGTH: marker_length <= wr_data[2:0];
        default: ;
      endcase
    end
  end

  // Gather the input word.
  always_comb begin
    in_item.pixel_byte = pixel_byte;
    in_item.first_byte = first_byte;
    in_item.last_byte  = last_byte;
  end

  lme_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_item   (s_item)
  );

  lme_extract u_extract (
    .clk           (clk),
    .rst           (rst),
    .marker_word   (marker_word),
    .marker_length (marker_length),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_item        (s_item),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  lme_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_res    (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // Split the result word onto the output ports.
  assign out_char   = out_res.out_char;
  assign char_valid = out_res.char_valid;
  assign status     = out_res.status;
  assign last       = out_res.last;

endmodule

### tb/sv/lsb_message_extractor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsb_message_extractor_tb: self-checking bench for the LSB message extractor
// Feeds image byte words through a queue-fed driver and predicts each
// result word with a cycle-free model of the marker match and character
// decode. A monitor compares every result word field by field. A directed
// part comes first, then random images under several marker settings.
// ----------------------------------------------------------------------------
module lsb_message_extractor_tb;
  import lme_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_BYTES = 35;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        wr_en = 1'b0;
  logic        wr_index = REG_MARKER_WORD;
  logic [31:0] wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  pixel_byte = '0;
  logic        first_byte = 1'b0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_char;
  logic        char_valid;
  logic [1:0]  status;
  logic        last;

  // Stimulus and checking state.
  item_t       image_bytes[$];
  result_t     decoded_words[$];
  result_t     want;
  logic        in_taken = 1'b0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int          hold_cnt = 0;
  int          mismatches = 0;
  int          gen_count = 0;
  int unsigned cycle_count = 0;

  // Local copy of the registers and the extraction state.
  logic [31:0] cfg_word = MARKER_WORD_RESET;
  logic [2:0]  cfg_len = MARKER_LENGTH_RESET;
  logic [7:0]  acc = '0;
  logic [2:0]  nbits = '0;
  logic [2:0]  midx = '0;
  phase_t      img_phase = PH_MARKER;

  lsb_message_extractor dut (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_byte (pixel_byte),
    .first_byte (first_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .char_valid (char_valid),
    .status     (status),
    .last       (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // The marker length in use is capped by the design limit.
  function automatic logic [2:0] marker_len_eff();
    return (cfg_len > MARKER_MAX) ? MARKER_MAX : cfg_len;
  endfunction

  // Advances the extraction state by one image byte and queues the result
  // word that byte produces, if any.
  task automatic extract_lsb(input item_t it);
    logic [2:0] n;
    logic [7:0] c;
    result_t    r;
    n = marker_len_eff();
    r = '{8'h00, 1'b0, STAT_BUSY, 1'b0};
    if (it.first_byte) begin
      acc = '0;
      nbits = '0;
      midx = '0;
      img_phase = PH_MARKER;
    end
    if (img_phase == PH_DONE) return;
    acc = {acc[6:0], it.pixel_byte[0]};
    nbits = nbits + 3'd1;
    if (nbits != 3'd0 && !it.last_byte) return;
    c = acc;
    acc = '0;
    nbits = '0;
    if (img_phase == PH_MARKER && midx >= n) img_phase = PH_MESSAGE;
    if (img_phase == PH_MARKER) begin
      if (c == 8'h00 || c != cfg_word[(3 - midx[1:0]) * 8 +: 8]) begin
        r.status = STAT_NO_MARKER;
        r.last = 1'b1;
        img_phase = PH_DONE;
      end else begin
        midx = midx + 3'd1;
        if (midx >= n) img_phase = PH_MESSAGE;
      end
    end else if (c == 8'h00) begin
      r.status = STAT_COMPLETE;
      r.last = 1'b1;
      img_phase = PH_DONE;
    end else begin
      r.out_char = c;
      r.char_valid = 1'b1;
    end
    // The image end closes the message on whatever character it carried.
    if (it.last_byte && img_phase != PH_DONE) begin
      r.status = (img_phase == PH_MARKER && midx < n) ? STAT_NO_MARKER : STAT_COMPLETE;
      r.last = 1'b1;
      img_phase = PH_DONE;
    end
    if (r.char_valid || r.last) decoded_words.insert(decoded_words.size(), r);
  endtask

  task automatic report_mismatch(input string field, input int got, input int exp_val);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, field, got, exp_val);
    mismatches++;
  endtask

  // Input driver: takes the next word once the current one is accepted.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (image_bytes.size() != 0 && !(idle_on && $urandom_range(99) < 17)) begin
        {pixel_byte, first_byte, last_byte} <= image_bytes.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: one long hold-off on request, otherwise random stalls.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else if (idle_on && $urandom_range(99) < 17) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predicts on accepted input words, checks accepted result words.
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      extract_lsb(item_t'({pixel_byte, first_byte, last_byte}));
    end
    if (!rst && out_valid && out_ready) begin
      if (decoded_words.size() == 0) begin
        report_mismatch("unexpected word", out_char, 0);
      end else begin
        want = decoded_words.pop_front();
        if (out_char !== want.out_char) report_mismatch("out_char", out_char, want.out_char);
        if (char_valid !== want.char_valid)
          report_mismatch("char_valid", char_valid, want.char_valid);
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (last !== want.last) report_mismatch("last", last, want.last);
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic push_raw(input logic [7:0] p, input bit f, input bit l);
    image_bytes.insert(image_bytes.size(),
                       item_t'{pixel_byte: p, first_byte: f, last_byte: l});
  endtask

  // Queues the low n bits of value, first bit most significant, one per byte.
  task automatic push_bits(input logic [7:0] value, input int n, input bit f, input bit l);
    logic [7:0] p;
    for (int i = n - 1; i >= 0; i--) begin
      p = 8'($urandom);
      p[0] = value[i];
      push_raw(p, f && i == n - 1, l && i == 0);
      gen_count++;
    end
  endtask

  // Waits until no word is in flight, then lets the pipeline settle.
  task automatic wait_drained();
    while (image_bytes.size() != 0 || in_valid || decoded_words.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(negedge clk);
    wr_en <= 1'b0;
    if (idx == REG_MARKER_WORD) cfg_word = data;
    else cfg_len = data[2:0];
  endtask

  // Length writes carry random upper bits, which must be ignored.
  task automatic set_marker(input logic [31:0] word, input logic [2:0] len);
    logic [31:0] len_data;
    wait_drained();
    len_data = $urandom;
    len_data[2:0] = len;
    write_reg(REG_MARKER_WORD, word);
    write_reg(REG_MARKER_LENGTH, len_data);
  endtask

  // One random image: mostly a proper marker and message with random
  // content and ending, some with a flipped bit, the rest plain noise.
  task automatic push_image();
    logic [7:0] chars[$];
    int         kind;
    int         ending;
    int         k;
    int         j;
    logic [2:0] n;
    n = marker_len_eff();
    kind = $urandom_range(99);
    if (kind >= 85) begin
      k = $urandom_range(1, 24);
      for (j = 0; j < k; j++) begin
        push_raw(8'($urandom), $urandom_range(9) == 0, $urandom_range(9) == 0);
        gen_count++;
      end
      return;
    end
    for (j = 0; j < n; j++) chars.insert(chars.size(), cfg_word[(3 - j) * 8 +: 8]);
    k = $urandom_range(5);
    for (j = 0; j < k; j++) chars.insert(chars.size(), 8'($urandom_range(1, 255)));
    // Endings: null character, last byte on a full character, partial group.
    ending = $urandom_range(2);
    if (ending == 0) chars.insert(chars.size(), 8'h00);
    if (ending == 1 && chars.size() == 0)
      chars.insert(chars.size(), 8'($urandom_range(1, 255)));
    if (kind >= 70 && chars.size() != 0) begin
      j = $urandom_range(chars.size() - 1);
      chars[j] = chars[j] ^ 8'(1 << $urandom_range(7));
    end
    for (j = 0; j < chars.size(); j++)
      push_bits(chars[j], 8, j == 0, ending == 1 && j == chars.size() - 1);
    if (ending == 2) push_bits(8'($urandom), $urandom_range(1, 7), chars.size() == 0, 1'b1);
    // Trailing bytes after a null are normally ignored by the block.
    if (ending == 0) begin
      k = $urandom_range(3);
      for (j = 0; j < k; j++) push_raw(8'($urandom), 1'b0, j == k - 1);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part on a one-character marker 'K'; the word also holds 0x05,
    // a null and 0xFF for the longer settings below.
    set_marker(32'h4B05_00FF, 3'd1);
    // No first_byte since reset: the stream counts as a started image.
    push_bits("K", 8, 1'b0, 1'b0);
    push_bits("a", 8, 1'b0, 1'b0);
    push_bits(8'h00, 8, 1'b0, 1'b0);
    // Bytes after the end are dropped.
    push_raw(8'h00, 1'b0, 1'b0);
    push_raw(8'hFF, 1'b0, 1'b1);
    // All-ones character from all-ones pixels, then a partial group on the end.
    push_bits("K", 8, 1'b1, 1'b0);
    for (int i = 0; i < 8; i++) push_raw(8'hFF, 1'b0, 1'b0);
    push_bits(8'h05, 3, 1'b0, 1'b1);
    // Character on the last byte, then an empty message.
    push_bits("K", 8, 1'b1, 1'b0);
    push_bits("z", 8, 1'b0, 1'b1);
    push_bits("K", 8, 1'b1, 1'b1);
    // Marker mismatch and null inside the marker.
    push_bits("X", 8, 1'b1, 1'b0);
    push_bits(8'h00, 8, 1'b1, 1'b0);
    // Restart in the middle of an image.
    push_bits("K", 8, 1'b1, 1'b0);
    push_bits(8'h09, 4, 1'b0, 1'b0);
    push_bits("K", 8, 1'b1, 1'b0);
    push_bits("b", 8, 1'b0, 1'b0);
    push_bits(8'h00, 8, 1'b0, 1'b0);
    // Image ends with the marker matched so far but not complete.
    set_marker(32'h4B05_00FF, 3'd3);
    push_bits("K", 8, 1'b1, 1'b0);
    push_bits(8'h05, 3, 1'b0, 1'b1);
    // Empty marker: message starts at once.
    set_marker(32'h4B05_00FF, 3'd0);
    push_bits("q", 8, 1'b1, 1'b0);
    push_bits(8'h00, 8, 1'b0, 1'b0);
    // Length shortened in the middle of the marker moves on to the message.
    set_marker(MARKER_WORD_RESET, 3'd7);
    push_bits("M", 8, 1'b1, 1'b0);
    set_marker(MARKER_WORD_RESET, 3'd1);
    push_bits("h", 8, 1'b0, 1'b0);
    push_bits(8'h00, 8, 1'b0, 1'b0);

    // Random images under several marker settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_marker(MARKER_WORD_RESET, MARKER_LENGTH_RESET);
        1: set_marker($urandom, 3'd1);
        2: set_marker($urandom, 3'd0);
        3: set_marker(32'hFFFF_FFFF, 3'd7);
        4: set_marker(32'h0000_0000, 3'd2);
        default: set_marker($urandom, 3'd3);
      endcase
      // One phase runs without any idling; another holds the receiver off.
      idle_on = (ph != 1);
      hold_req = (ph == 2);
      gen_count = 0;
      while (gen_count < PHASE_BYTES) push_image();
    end

    wait_drained();
    if (mismatches == 0 && decoded_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
rtl/lme_pkg.sv
rtl/lme_in_reg.sv
rtl/lme_extract.sv
rtl/lme_out_reg.sv
rtl/lsb_message_extractor.sv
tb/sv/lsb_message_extractor_tb.sv
